// File: hw/rtl/bsh_pkg.sv
// ----------------------------------------------------------------------------
// bsh_pkg
// Shared types and constants of the bilinear spline 2-D histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh_pkg;

    localparam int E_BINS_DEF     = 64;
    localparam int OMEGA_BINS_DEF = 64;
    localparam int ACC_WIDTH_DEF  = 48;

    localparam int BIN_W    = 48;
    localparam int FRAC_W   = 16;
    localparam int CFG_AW   = 5;
    localparam int USED_W   = 7;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        STS_ADDED = 2'd0,
        STS_DROP  = 2'd1,
        STS_READ  = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_E_MIN      = 3'd0,
        REG_E_INV      = 3'd1,
        REG_O_MIN      = 3'd2,
        REG_O_INV      = 3'd3,
        REG_E_USED     = 3'd4,
        REG_O_USED     = 3'd5,
        REG_NORM       = 3'd6,
        REG_NONE       = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_LOC,
        ST_SCALE,
        ST_UPD,
        ST_WB,
        ST_RCHK,
        ST_RWAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/bsh_mem.sv
// ----------------------------------------------------------------------------
// bsh_mem
// Bin store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bsh_sat.sv
// ----------------------------------------------------------------------------
// bsh_sat
// Saturating addition of one bin contribution to a stored bin.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_sat
    import bsh_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic [ACC_WIDTH-1:0] i_old,
    input  wire logic [BIN_W-1:0]     i_inc,
    output logic      [ACC_WIDTH-1:0] o_new
);

    localparam int SW = ((ACC_WIDTH > BIN_W) ? ACC_WIDTH : BIN_W) + 1;

    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_hi;
    logic signed [SW-1:0] w_lo;

    always_comb begin
        w_hi  = $signed({{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
        w_lo  = ~w_hi;
        w_sum = $signed({{(SW-ACC_WIDTH){i_old[ACC_WIDTH-1]}}, i_old})
              + $signed({{(SW-BIN_W){i_inc[BIN_W-1]}}, i_inc});
        if (w_sum > w_hi) begin
            o_new = w_hi[ACC_WIDTH-1:0];
        end else if (w_sum < w_lo) begin
            o_new = w_lo[ACC_WIDTH-1:0];
        end else begin
            o_new = w_sum[ACC_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bilinear_spline_histogram_2d_unit.sv
// ----------------------------------------------------------------------------
// bilinear_spline_histogram_2d_unit
// Bilinear splatting of weighted events into a saturating 2-D histogram.
// ----------------------------------------------------------------------------
// An add word passes locate, weight and scale stages, then four read-modify-write
// bin updates, one per cycle, and a final write. A dropped add ends after the locate
// stage; a read waits for the bin store, and a read out of range skips that wait. One
// word is worked on at a time; the next can be accepted in the cycle after the result
// is loaded. After reset the store is swept to zero, one bin a cycle, and no word is
// accepted during the sweep.
`default_nettype none

module bilinear_spline_histogram_2d_unit
    import bsh_pkg::*;
#(
    parameter int E_BINS     = E_BINS_DEF,
    parameter int OMEGA_BINS = OMEGA_BINS_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // e_value, omega_value, weight, read_e_bin, read_omega_bin
    input  wire logic [111:0]      i_s_tdata,
    // cmd
    input  wire logic              i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // bin_value
    output logic [BIN_W-1:0]       o_m_tdata,
    // status
    output logic [1:0]             o_m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DEPTH = E_BINS * OMEGA_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EIW   = $clog2(E_BINS);
    localparam int OIW   = $clog2(OMEGA_BINS);

    t_state r_state, n_state;

    logic [31:0] r_e_min, r_e_inv, r_o_min, r_o_inv, r_norm;
    logic [USED_W-1:0] r_e_used, r_o_used;

    logic r_cmd;
    logic [31:0] r_ev, r_ov, r_w;
    logic [5:0] r_re, r_ro;

    logic [63:0] r_prod_e, r_prod_o;
    logic r_neg_drop;
    logic [BIN_W-1:0] r_p, r_e0, r_e1, r_c;
    logic [FRAC_W-1:0] r_te, r_to;
    logic [AW-1:0] r_addr, r_ne, r_wa, r_clr;
    logic [1:0] r_k;
    logic r_upd_v;
    t_status r_res_status;
    logic [BIN_W-1:0] r_res_bin;
    logic r_out_valid;
    t_status r_out_status;
    logic [BIN_W-1:0] r_out_bin;

    logic [32:0] w_de, w_do;
    logic [31:0] w_diff_e, w_diff_o;
    logic signed [64:0] w_pw, w_e0, w_e1, w_c;
    logic [31:0] w_ne32, w_no32, w_ib_e, w_ib_o;
    logic w_drop, w_roob, w_accept, w_cfg_wr, w_load;
    logic [16:0] w_wt;
    logic [BIN_W-1:0] w_ex;
    logic [AW-1:0] w_base, w_raddr, w_off;
    logic w_wr_en, w_rd_en;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic [ACC_WIDTH-1:0] w_wr_data, w_rd_data, w_sat;
    logic signed [63:0] w_rd_ext;
    t_reg w_reg;

    assign pready   = 1'b1;
    assign w_reg    = t_reg'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_min  <= '0;
            r_e_inv  <= 32'h0001_0000;
            r_o_min  <= '0;
            r_o_inv  <= 32'h0001_0000;
            r_e_used <= USED_W'(64);
            r_o_used <= USED_W'(64);
            r_norm   <= 32'h0001_0000;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_E_MIN:  r_e_min  <= pwdata;
                REG_E_INV:  r_e_inv  <= pwdata;
                REG_O_MIN:  r_o_min  <= pwdata;
                REG_O_INV:  r_o_inv  <= pwdata;
                REG_E_USED: r_e_used <= pwdata[USED_W-1:0];
                REG_O_USED: r_o_used <= pwdata[USED_W-1:0];
                REG_NORM:   r_norm   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_E_MIN:  prdata = r_e_min;
            REG_E_INV:  prdata = r_e_inv;
            REG_O_MIN:  prdata = r_o_min;
            REG_O_INV:  prdata = r_o_inv;
            REG_E_USED: prdata = {25'b0, r_e_used};
            REG_O_USED: prdata = {25'b0, r_o_used};
            REG_NORM:   prdata = r_norm;
            default:    prdata = '0;
        endcase
    end

    assign w_ne32 = ({25'b0, r_e_used} > 32'(E_BINS)) ? 32'(E_BINS) : {25'b0, r_e_used};
    assign w_no32 = ({25'b0, r_o_used} > 32'(OMEGA_BINS)) ? 32'(OMEGA_BINS)
                                                          : {25'b0, r_o_used};

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Offset of both coordinates, and the weight normalization.
    always_comb begin
        w_de     = {r_ev[31], r_ev} - {r_e_min[31], r_e_min};
        w_do     = {r_ov[31], r_ov} - {r_o_min[31], r_o_min};
        w_diff_e = w_de[32] ? 32'd0 : w_de[31:0];
        w_diff_o = w_do[32] ? 32'd0 : w_do[31:0];
        w_pw     = $signed({{33{r_w[31]}}, r_w}) * $signed({33'b0, r_norm});
    end

    // Bin index, drop decision, base address, and the read range check and address.
    always_comb begin
        w_ib_e = r_prod_e[63:32];
        w_ib_o = r_prod_o[63:32];
        w_drop = r_neg_drop
              || (({1'b0, w_ib_e} + 33'd1) >= {1'b0, w_ne32})
              || (({1'b0, w_ib_o} + 33'd1) >= {1'b0, w_no32});
        w_base = AW'(AW'(w_ib_o[OIW-1:0]) * w_ne32[AW-1:0]) + AW'(w_ib_e[EIW-1:0]);
        w_roob = ({26'b0, r_re} >= w_ne32) || ({26'b0, r_ro} >= w_no32);
        w_raddr = AW'(AW'(r_ro) * w_ne32[AW-1:0]) + AW'(r_re);
    end

    // Energy weights of the two neighbor columns.
    always_comb begin
        w_e0 = $signed({{17{r_p[BIN_W-1]}}, r_p}) * $signed({48'b0, ONE_Q16 - {1'b0, r_te}});
        w_e1 = $signed({{17{r_p[BIN_W-1]}}, r_p}) * $signed({48'b0, 1'b0, r_te});
    end

    // Contribution of the bin updated in this cycle.
    always_comb begin
        w_ex = r_k[0] ? r_e1 : r_e0;
        w_wt = r_k[1] ? {1'b0, r_to} : (ONE_Q16 - {1'b0, r_to});
        w_c  = $signed({{17{w_ex[BIN_W-1]}}, w_ex}) * $signed({48'b0, w_wt});
        unique case (r_k)
            2'd0:    w_off = '0;
            2'd1:    w_off = AW'(1);
            2'd2:    w_off = r_ne;
            default: w_off = r_ne + AW'(1);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) n_state = i_s_tuser ? ST_RCHK : ST_MUL;
            end
            ST_MUL:   n_state = ST_LOC;
            ST_LOC:   n_state = w_drop ? ST_DONE : ST_SCALE;
            ST_SCALE: n_state = ST_UPD;
            ST_UPD: begin
                if (r_k == 2'd3) n_state = ST_WB;
            end
            ST_WB:    n_state = ST_DONE;
            ST_RCHK:  n_state = w_roob ? ST_DONE : ST_RWAIT;
            ST_RWAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_k     <= '0;
            r_upd_v <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            r_k     <= (r_state == ST_UPD) ? r_k + 2'd1 : 2'd0;
            r_upd_v <= (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_tuser;
            r_ev  <= i_s_tdata[31:0];
            r_ov  <= i_s_tdata[63:32];
            r_w   <= i_s_tdata[95:64];
            r_re  <= i_s_tdata[101:96];
            r_ro  <= i_s_tdata[107:102];
        end
        if (r_state == ST_MUL) begin
            r_prod_e   <= w_diff_e * r_e_inv;
            r_prod_o   <= w_diff_o * r_o_inv;
            r_neg_drop <= (w_de[32] && (r_e_inv != 32'd0))
                       || (w_do[32] && (r_o_inv != 32'd0));
            r_p        <= w_pw[63:16];
        end
        if (r_state == ST_LOC) begin
            r_te   <= r_prod_e[31:16];
            r_to   <= r_prod_o[31:16];
            r_addr <= w_base;
            r_ne   <= w_ne32[AW-1:0];
        end
        if (r_state == ST_SCALE) begin
            r_e0 <= w_e0[63:16];
            r_e1 <= w_e1[63:16];
        end
        if (r_state == ST_UPD) begin
            r_c  <= w_c[63:16];
            r_wa <= r_addr + w_off;
        end
        unique case (r_state)
            ST_LOC:   begin
                r_res_status <= STS_DROP;
                r_res_bin    <= '0;
            end
            ST_WB:    begin
                r_res_status <= STS_ADDED;
                r_res_bin    <= '0;
            end
            ST_RCHK:  begin
                r_res_status <= STS_RANGE;
                r_res_bin    <= '0;
            end
            ST_RWAIT: begin
                r_res_status <= STS_READ;
                r_res_bin    <= w_rd_ext[BIN_W-1:0];
            end
            default: ;
        endcase
    end

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_bin    <= r_res_bin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_bin;
    assign o_m_tuser  = r_out_status;

    assign w_rd_ext  = 64'($signed(w_rd_data));
    assign w_wr_en   = (r_state == ST_CLEAR) || r_upd_v;
    assign w_wr_addr = (r_state == ST_CLEAR) ? r_clr : r_wa;
    assign w_wr_data = (r_state == ST_CLEAR) ? '0 : w_sat;
    assign w_rd_en   = (r_state == ST_UPD) || ((r_state == ST_RCHK) && !w_roob && r_cmd);
    assign w_rd_addr = (r_state == ST_UPD) ? (r_addr + w_off) : w_raddr;

    bsh_sat #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_sat (
        .i_old (w_rd_data),
        .i_inc (r_c),
        .o_new (w_sat)
    );

    bsh_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ACC_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    a_upd_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd_v |-> (r_state == ST_UPD || r_state == ST_WB))
        else $error("bin write outside the update window");

    a_zero_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != STS_READ) |-> (o_m_tdata == '0))
        else $error("nonzero bin value on a non-read result");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_tready)
        else $error("word accepted during the clearing sweep");

endmodule

`default_nettype wire
